FILE: design/vsfr_pkg.sv
`timescale 1ns / 1ps

package vsfr_pkg;

    localparam int COUNT_WIDTH      = 16;
    localparam int VOLTAGE_BITS     = 10;
    localparam int EDGE_COUNT_WIDTH = 8;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = COUNT_WIDTH;

    // product of (period + 1) and edge count for the edge acceptance check
    localparam int ACC_PROD_WIDTH = COUNT_WIDTH + 1 + EDGE_COUNT_WIDTH;
    // product of voltage offset and halved interval for the limit scaling
    localparam int SCL_PROD_WIDTH = VOLTAGE_BITS + COUNT_WIDTH - 1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TICK_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STOP_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_PERIOD_BASE = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_VOLTAGE_CENTER  = 3'd4;

    localparam logic [COUNT_WIDTH-1:0]  RST_TICK_TIMEOUT    = COUNT_WIDTH'(6000);
    localparam logic [COUNT_WIDTH-1:0]  RST_STOP_THRESHOLD  = COUNT_WIDTH'(16'h1400);
    localparam logic [COUNT_WIDTH-1:0]  RST_START_THRESHOLD = COUNT_WIDTH'(16'h1200);
    localparam logic [COUNT_WIDTH-1:0]  RST_MIN_PERIOD_BASE = COUNT_WIDTH'(3906);
    localparam logic [VOLTAGE_BITS-1:0] RST_VOLTAGE_CENTER  = VOLTAGE_BITS'(10'h200);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_EDGE = 2'd1,
        OP_EVAL = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     operation;
        logic [COUNT_WIDTH-1:0]  edge_period;
        logic [VOLTAGE_BITS-1:0] voltage_sample;
    } t_in_word;

    typedef struct packed {
        logic                        out_level;
        logic                        measuring;
        logic [COUNT_WIDTH-1:0]      half_period_limit;
        logic [EDGE_COUNT_WIDTH-1:0] edges_seen;
        logic [COUNT_WIDTH-1:0]      last_interval_out;
    } t_out_word;

    typedef struct packed {
        logic load;   // capture the input word
        logic calc;   // register the products
        logic apply;  // update state and load the result register
    } t_dp_cmd;

endpackage

FILE: design/vsfr_ctrl.sv
`timescale 1ns / 1ps

module vsfr_ctrl
    import vsfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_APPLY
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/vsfr_datapath.sv
`timescale 1ns / 1ps

module vsfr_datapath
    import vsfr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  t_in_word                  i_in_word,
    output t_out_word                 o_out_word
);

    localparam logic [EDGE_COUNT_WIDTH-1:0] EDGE_MAX = {EDGE_COUNT_WIDTH{1'b1}};

    // configuration
    logic [COUNT_WIDTH-1:0]  r_cfg_timeout, r_cfg_stop, r_cfg_start, r_cfg_base;
    logic [VOLTAGE_BITS-1:0] r_cfg_center;

    // captured input word
    t_in_word r_in;

    // block state
    logic [COUNT_WIDTH-1:0]      r_tick, r_last_interval, r_out_count, r_half_limit;
    logic                        r_pending, r_mode, r_level;
    logic [EDGE_COUNT_WIDTH-1:0] r_edge_count;
    logic [VOLTAGE_BITS-1:0]     r_voltage;

    logic [COUNT_WIDTH-1:0]      n_tick, n_last_interval, n_out_count, n_half_limit;
    logic                        n_pending, n_mode, n_level;
    logic [EDGE_COUNT_WIDTH-1:0] n_edge_count;
    logic [VOLTAGE_BITS-1:0]     n_voltage;

    // product stage
    logic [ACC_PROD_WIDTH-1:0] r_acc_prod;
    logic [SCL_PROD_WIDTH-1:0] r_scl_prod;
    logic                      r_grow;

    t_out_word r_out;

    logic [EDGE_COUNT_WIDTH-1:0] w_edge_inc;
    logic [VOLTAGE_BITS-1:0]     w_vdiff;
    logic [COUNT_WIDTH:0]        w_period_p1;
    logic [COUNT_WIDTH-1:0]      w_lim, w_d, w_new_lim, w_tick_inc, w_oc_inc;
    logic [COUNT_WIDTH:0]        w_sum;
    logic                        w_reject;

    assign w_edge_inc  = (r_edge_count != EDGE_MAX) ? r_edge_count + 1'b1 : r_edge_count;
    assign w_vdiff     = (r_voltage > r_cfg_center) ? r_voltage - r_cfg_center
                                                    : r_cfg_center - r_voltage;
    assign w_period_p1 = {1'b0, r_in.edge_period} + 1'b1;

    // scaled limit from the registered product
    assign w_lim = {1'b0, r_tick[COUNT_WIDTH-1:1]};
    assign w_d   = {1'b0, r_scl_prod[SCL_PROD_WIDTH-1:VOLTAGE_BITS]};
    assign w_sum = {1'b0, w_lim} + {1'b0, w_d};
    always_comb begin
        if (r_grow) begin
            w_new_lim = w_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : w_sum[COUNT_WIDTH-1:0];
        end else begin
            w_new_lim = (w_d >= w_lim) ? '0 : w_lim - w_d;
        end
    end

    // period < base / count  <=>  (period + 1) * count <= base
    assign w_reject   = r_mode &&
                        (r_acc_prod <= {{(ACC_PROD_WIDTH-COUNT_WIDTH){1'b0}}, r_cfg_base});
    assign w_tick_inc = r_tick + 1'b1;
    assign w_oc_inc   = r_out_count + 1'b1;

    always_comb begin
        n_tick          = r_tick;
        n_last_interval = r_last_interval;
        n_out_count     = r_out_count;
        n_half_limit    = r_half_limit;
        n_pending       = r_pending;
        n_mode          = r_mode;
        n_level         = r_level;
        n_edge_count    = r_edge_count;
        n_voltage       = r_voltage;
        case (r_in.operation)
            OP_TICK: begin
                if (w_tick_inc >= r_cfg_timeout) begin
                    n_tick          = '0;
                    n_last_interval = '0;
                    n_pending       = 1'b0;
                    n_mode          = 1'b0;
                end else begin
                    n_tick = w_tick_inc;
                    if (w_oc_inc > r_half_limit) begin
                        n_pending   = 1'b1;
                        n_out_count = '0;
                    end else begin
                        n_out_count = w_oc_inc;
                    end
                end
            end
            OP_EDGE: begin
                n_edge_count    = w_edge_inc;
                n_last_interval = r_tick;
                if (!w_reject) begin
                    n_half_limit = w_new_lim;
                    n_tick       = '0;
                    if (r_out_count > w_new_lim) begin
                        n_out_count = '0;
                        n_pending   = 1'b1;
                    end
                end
            end
            OP_EVAL: begin
                n_voltage = r_in.voltage_sample;
                if (r_mode) begin
                    if (r_last_interval == '0 || r_edge_count == '0 ||
                        r_last_interval > r_cfg_stop) begin
                        n_mode = 1'b0;
                    end
                end else begin
                    if (r_last_interval != '0 && r_edge_count >= EDGE_COUNT_WIDTH'(2) &&
                        r_last_interval < r_cfg_start) begin
                        n_mode = 1'b1;
                    end
                end
                n_edge_count = '0;
            end
            default: ;
        endcase
        // serve a pending toggle only while measuring
        if (n_pending && n_mode) begin
            n_level   = !r_level;
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_timeout   <= RST_TICK_TIMEOUT;
            r_cfg_stop      <= RST_STOP_THRESHOLD;
            r_cfg_start     <= RST_START_THRESHOLD;
            r_cfg_base      <= RST_MIN_PERIOD_BASE;
            r_cfg_center    <= RST_VOLTAGE_CENTER;
            r_tick          <= '0;
            r_last_interval <= '0;
            r_out_count     <= '0;
            r_half_limit    <= '0;
            r_pending       <= 1'b0;
            r_mode          <= 1'b0;
            r_level         <= 1'b0;
            r_edge_count    <= '0;
            r_voltage       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TICK_TIMEOUT:    r_cfg_timeout <= i_cfg_data;
                    CFG_STOP_THRESHOLD:  r_cfg_stop    <= i_cfg_data;
                    CFG_START_THRESHOLD: r_cfg_start   <= i_cfg_data;
                    CFG_MIN_PERIOD_BASE: r_cfg_base    <= i_cfg_data;
                    CFG_VOLTAGE_CENTER:  r_cfg_center  <= i_cfg_data[VOLTAGE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.apply) begin
                r_tick          <= n_tick;
                r_last_interval <= n_last_interval;
                r_out_count     <= n_out_count;
                r_half_limit    <= n_half_limit;
                r_pending       <= n_pending;
                r_mode          <= n_mode;
                r_level         <= n_level;
                r_edge_count    <= n_edge_count;
                r_voltage       <= n_voltage;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.calc) begin
            r_acc_prod <= w_period_p1 * w_edge_inc;
            r_scl_prod <= w_vdiff * r_tick[COUNT_WIDTH-1:1];
            r_grow     <= (r_voltage > r_cfg_center);
        end
        if (i_cmd.apply) begin
            r_out.out_level         <= n_level;
            r_out.measuring         <= n_mode;
            r_out.half_period_limit <= n_half_limit;
            r_out.edges_seen        <= n_edge_count;
            r_out.last_interval_out <= n_last_interval;
        end
    end

    assign o_out_word = r_out;

endmodule

FILE: design/voltage_scaled_frequency_regenerator_unit.sv
`timescale 1ns / 1ps

// Voltage-scaled frequency regenerator. Each input word is a tick, an input
// edge with its coarse period, or a one-second evaluation with a voltage
// sample; every word yields exactly one result word with the output level,
// the mode, the half-period limit, the edge count and the last interval.
// Each word passes through capture, a step in which the two multipliers
// (edge acceptance check and voltage scaling of the limit) are registered,
// and an update step that writes the state and the result register. The
// result register lets the next word in while a result is still stalled;
// the update step then waits for that register to drain. Configuration
// writes through i_cfg_we/i_cfg_idx/i_cfg_data take effect at once and are
// meant to be issued while no word is in flight; unknown indexes are dropped.

module voltage_scaled_frequency_regenerator_unit
    import vsfr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_word                  i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_word                 o_out_word
);

    t_dp_cmd w_cmd;

    // sequencing: capture, multiply, update
    vsfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // configuration, block state, multipliers and result register
    vsfr_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule
